/* hw/rtl/variable_length_message_ring_macros.svh */
// Assertion macros for the variable length message ring.
// Included by the top level; no other dependencies.
`ifndef VARIABLE_LENGTH_MESSAGE_RING_MACROS_SVH
`define VARIABLE_LENGTH_MESSAGE_RING_MACROS_SVH

// same-cycle implication
`define VLMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VLMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/vlmr_pkg.sv */
// Types and constants shared by the message ring controller, datapath and top.
// No dependencies.
`default_nettype none

package vlmr_pkg;

    localparam int DATA_W = 32;
    localparam int MSG_W  = 10;
    localparam int CAP_W  = 12;
    localparam int PAD_W  = 11;
    localparam int CNT_W  = 9;
    localparam int PEND_W = 7;

    localparam logic [DATA_W-1:0] HEADER_MARK = 32'h1234_4321;
    localparam logic [PEND_W-1:0] PENDING_MAX = 7'd127;
    localparam int                SLACK_WORDS = 4;
    localparam int                HEADER_WORDS = 2;

    typedef enum logic [1:0] {
        CMD_SEND_START = 2'd0,
        CMD_SEND_WORD  = 2'd1,
        CMD_RECV_START = 2'd2,
        CMD_RECV_WORD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DISABLED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_TOO_SMALL = 3'd4,
        ST_SEQ_ERR   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_HDR1,
        S_RDHDR,
        S_RDDAT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEND_OPEN,
        OP_HDR1,
        OP_SEND_WORD,
        OP_RD_HDR,
        OP_RECV_OPEN,
        OP_RD_DATA,
        OP_RECV_WORD
    } t_dp_op;

    typedef enum logic [1:0] {
        PAD_NONE,
        PAD_SEND,
        PAD_RECV
    } t_pad_sel;

    typedef struct packed {
        logic     latch;
        t_dp_op   op;
        logic     out_load;
        t_status  out_status;
        t_pad_sel pad_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic enable;
        t_cmd cmd;
        logic send_open;
        logic recv_open;
        logic pending_zero;
        logic send_refuse;
        logic cap_small;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hw/rtl/vlmr_if.sv */
// Request channel interfaces of the message ring: input, result, configuration.
// Depends on vlmr_pkg for field widths.
`default_nettype none

interface vlmr_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic [vlmr_pkg::MSG_W-1:0]   message_bytes;
    logic [vlmr_pkg::CAP_W-1:0]   capacity_bytes;
    logic [vlmr_pkg::DATA_W-1:0]  data_in;

    modport source (output valid, command, message_bytes, capacity_bytes, data_in,
                    input ready);
    modport sink   (input valid, command, message_bytes, capacity_bytes, data_in,
                    output ready);
endinterface

interface vlmr_out_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [vlmr_pkg::PAD_W-1:0]   padded_bytes;
    logic [vlmr_pkg::DATA_W-1:0]  data_out;
    logic                         last;

    modport source (output valid, status, padded_bytes, data_out, last, input ready);
    modport sink   (input valid, status, padded_bytes, data_out, last, output ready);
endinterface

interface vlmr_cfg_if;
    logic valid;
    logic ready;
    logic queue_enable;

    modport source (output valid, queue_enable, input ready);
    modport sink   (input valid, queue_enable, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vlmr_ctrl.sv */
// Message ring controller: sequences one request through evaluate, store
// access and result hand-off. Depends on vlmr_pkg.
`default_nettype none

module vlmr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_out_ready,
    input  wire vlmr_pkg::t_dp_stat i_stat,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output vlmr_pkg::t_dp_cmd       o_cmd
);

    vlmr_pkg::t_state r_state;
    vlmr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vlmr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_cmd.latch      = 1'b0;
        o_cmd.op         = vlmr_pkg::OP_NONE;
        o_cmd.out_load   = 1'b0;
        o_cmd.out_status = vlmr_pkg::ST_OK;
        o_cmd.pad_sel    = vlmr_pkg::PAD_NONE;
        case (r_state)
            vlmr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = vlmr_pkg::S_EVAL;
                end
            end
            vlmr_pkg::S_EVAL: begin
                n_state = vlmr_pkg::S_OUT;
                if (!i_stat.enable) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = vlmr_pkg::ST_DISABLED;
                end else begin
                    case (i_stat.cmd)
                        vlmr_pkg::CMD_SEND_START: begin
                            if (i_stat.send_open) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = vlmr_pkg::ST_SEQ_ERR;
                            end else if (i_stat.send_refuse) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = vlmr_pkg::ST_FULL;
                                o_cmd.pad_sel    = vlmr_pkg::PAD_SEND;
                            end else begin
                                o_cmd.op = vlmr_pkg::OP_SEND_OPEN;
                                n_state  = vlmr_pkg::S_HDR1;
                            end
                        end
                        vlmr_pkg::CMD_SEND_WORD: begin
                            o_cmd.out_load = 1'b1;
                            if (!i_stat.send_open) begin
                                o_cmd.out_status = vlmr_pkg::ST_SEQ_ERR;
                            end else begin
                                o_cmd.op = vlmr_pkg::OP_SEND_WORD;
                            end
                        end
                        vlmr_pkg::CMD_RECV_START: begin
                            if (i_stat.recv_open) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = vlmr_pkg::ST_SEQ_ERR;
                            end else if (i_stat.pending_zero) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = vlmr_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.op = vlmr_pkg::OP_RD_HDR;
                                n_state  = vlmr_pkg::S_RDHDR;
                            end
                        end
                        vlmr_pkg::CMD_RECV_WORD: begin
                            if (!i_stat.recv_open) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = vlmr_pkg::ST_SEQ_ERR;
                            end else begin
                                o_cmd.op = vlmr_pkg::OP_RD_DATA;
                                n_state  = vlmr_pkg::S_RDDAT;
                            end
                        end
                        default: begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = vlmr_pkg::ST_SEQ_ERR;
                        end
                    endcase
                end
            end
            vlmr_pkg::S_HDR1: begin
                o_cmd.op       = vlmr_pkg::OP_HDR1;
                o_cmd.out_load = 1'b1;
                o_cmd.pad_sel  = vlmr_pkg::PAD_SEND;
                n_state        = vlmr_pkg::S_OUT;
            end
            vlmr_pkg::S_RDHDR: begin
                o_cmd.out_load = 1'b1;
                o_cmd.pad_sel  = vlmr_pkg::PAD_RECV;
                if (i_stat.cap_small) begin
                    o_cmd.out_status = vlmr_pkg::ST_TOO_SMALL;
                end else begin
                    o_cmd.op = vlmr_pkg::OP_RECV_OPEN;
                end
                n_state = vlmr_pkg::S_OUT;
            end
            vlmr_pkg::S_RDDAT: begin
                o_cmd.op       = vlmr_pkg::OP_RECV_WORD;
                o_cmd.out_load = 1'b1;
                n_state        = vlmr_pkg::S_OUT;
            end
            vlmr_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = vlmr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vlmr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/vlmr_dp.sv */
// Message ring datapath: word store, ring pointers, transfer counters,
// latched request and result register. Depends on vlmr_pkg.
`default_nettype none

module vlmr_dp #(
    parameter int QUEUE_BYTES = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire vlmr_pkg::t_dp_cmd           i_cmd,
    output vlmr_pkg::t_dp_stat               o_stat,
    input  wire logic [1:0]                  i_command,
    input  wire logic [vlmr_pkg::MSG_W-1:0]  i_message_bytes,
    input  wire logic [vlmr_pkg::CAP_W-1:0]  i_capacity_bytes,
    input  wire logic [vlmr_pkg::DATA_W-1:0] i_data_in,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_queue_enable,
    output logic [2:0]                       o_status,
    output logic [vlmr_pkg::PAD_W-1:0]       o_padded_bytes,
    output logic [vlmr_pkg::DATA_W-1:0]      o_data_out,
    output logic                             o_last
);

    localparam int STORE_WORDS = QUEUE_BYTES / 4;
    localparam int PTR_W       = $clog2(STORE_WORDS);
    localparam int FREE_W      = $clog2(STORE_WORDS + 1);
    localparam int NEED_W      = vlmr_pkg::CNT_W + 1;
    localparam int CMP_W       = (FREE_W > NEED_W) ? FREE_W : NEED_W;
    localparam int ADD_W       = vlmr_pkg::CNT_W + 1;
    localparam int SUM_W       = ((PTR_W > ADD_W) ? PTR_W : ADD_W) + 1;
    localparam int DW          = vlmr_pkg::DATA_W;
    localparam int PW          = vlmr_pkg::PAD_W;
    localparam int CW          = vlmr_pkg::CNT_W;

    localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(STORE_WORDS - 1);
    localparam logic [FREE_W-1:0] FULL_WORDS = FREE_W'(STORE_WORDS);

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [ADD_W-1:0] add);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(add);
        if (sum >= SUM_W'(STORE_WORDS)) begin
            sum = sum - SUM_W'(STORE_WORDS);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] header_at(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p;
    endfunction

    logic                       r_enable;
    logic [PTR_W-1:0]           r_wp;
    logic [PTR_W-1:0]           r_rp;
    logic [vlmr_pkg::PEND_W-1:0] r_pending;
    logic [CW-1:0]              r_sleft;
    logic [CW-1:0]              r_rleft;
    logic [PTR_W-1:0]           r_scur;
    logic [PTR_W-1:0]           r_rcur;
    logic [PTR_W-1:0]           r_hdr1;

    vlmr_pkg::t_cmd             r_cmd;
    logic [vlmr_pkg::MSG_W-1:0] r_msg;
    logic [vlmr_pkg::CAP_W-1:0] r_cap;
    logic [DW-1:0]              r_din;

    logic [DW-1:0]              r_mem [STORE_WORDS];
    logic [DW-1:0]              r_rdata;

    vlmr_pkg::t_status          r_out_status;
    logic [PW-1:0]              r_out_padded;
    logic [DW-1:0]              r_out_data;
    logic                       r_out_last;

    logic [PW-1:0]              msg_plus;
    logic [CW-1:0]              n_send;
    logic [PW-1:0]              pad_send;
    logic [PW-1:0]              pad_recv;
    logic [CW-1:0]              n_recv;
    logic [FREE_W-1:0]          free_words;
    logic [NEED_W-1:0]          need_words;
    logic [PTR_W-1:0]           h_w;
    logic [PTR_W-1:0]           h_r;
    logic                       mem_we;
    logic [PTR_W-1:0]           mem_waddr;
    logic [DW-1:0]              mem_wdata;
    logic                       mem_re;
    logic [PTR_W-1:0]           mem_raddr;

    assign msg_plus   = PW'(r_msg) + PW'(4);
    assign n_send     = msg_plus[PW-1:2];
    assign pad_send   = {n_send, 2'b00};
    assign pad_recv   = r_rdata[PW-1:0];
    assign n_recv     = (pad_recv[PW-1:2] == '0) ? CW'(1) : pad_recv[PW-1:2];
    assign h_w        = header_at(r_wp);
    assign h_r        = header_at(r_rp);
    assign free_words = (r_wp >= r_rp) ? FULL_WORDS - FREE_W'(r_wp - r_rp)
                                       : FREE_W'(r_rp - r_wp);
    assign need_words = NEED_W'(n_send) + NEED_W'(vlmr_pkg::SLACK_WORDS);

    assign o_stat.enable       = r_enable;
    assign o_stat.cmd          = r_cmd;
    assign o_stat.send_open    = (r_sleft != '0);
    assign o_stat.recv_open    = (r_rleft != '0);
    assign o_stat.pending_zero = (r_pending == '0);
    assign o_stat.send_refuse  = (CMP_W'(free_words) < CMP_W'(need_words))
                               || (r_pending == vlmr_pkg::PENDING_MAX);
    assign o_stat.cap_small    = (r_cap < vlmr_pkg::CAP_W'(pad_recv));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_scur;
        mem_wdata = r_din;
        mem_re    = 1'b0;
        mem_raddr = r_rcur;
        case (i_cmd.op)
            vlmr_pkg::OP_SEND_OPEN: begin
                mem_we    = 1'b1;
                mem_waddr = h_w;
                mem_wdata = vlmr_pkg::HEADER_MARK;
            end
            vlmr_pkg::OP_HDR1: begin
                mem_we    = 1'b1;
                mem_waddr = r_hdr1;
                mem_wdata = DW'(pad_send);
            end
            vlmr_pkg::OP_SEND_WORD: begin
                mem_we = 1'b1;
            end
            vlmr_pkg::OP_RD_HDR: begin
                mem_re    = 1'b1;
                mem_raddr = h_r + PTR_W'(1);
            end
            vlmr_pkg::OP_RD_DATA: begin
                mem_re = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_pending <= '0;
            r_sleft   <= '0;
            r_rleft   <= '0;
            r_scur    <= '0;
            r_rcur    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_queue_enable;
            end
            case (i_cmd.op)
                vlmr_pkg::OP_SEND_OPEN: begin
                    r_scur  <= wrap_add(h_w, ADD_W'(vlmr_pkg::HEADER_WORDS));
                    r_sleft <= n_send;
                    r_wp    <= wrap_add(h_w, ADD_W'(n_send)
                                             + ADD_W'(vlmr_pkg::HEADER_WORDS));
                end
                vlmr_pkg::OP_SEND_WORD: begin
                    r_scur  <= wrap_add(r_scur, ADD_W'(1));
                    r_sleft <= r_sleft - CW'(1);
                    if (r_sleft == CW'(1)) begin
                        r_pending <= r_pending + vlmr_pkg::PEND_W'(1);
                    end
                end
                vlmr_pkg::OP_RECV_OPEN: begin
                    r_rcur  <= wrap_add(h_r, ADD_W'(vlmr_pkg::HEADER_WORDS));
                    r_rleft <= n_recv;
                end
                vlmr_pkg::OP_RECV_WORD: begin
                    r_rcur  <= wrap_add(r_rcur, ADD_W'(1));
                    r_rleft <= r_rleft - CW'(1);
                    if (r_rleft == CW'(1)) begin
                        r_rp <= wrap_add(r_rcur, ADD_W'(1));
                        if (r_pending != '0) begin
                            r_pending <= r_pending - vlmr_pkg::PEND_W'(1);
                        end
                    end
                end
                default: begin
                    r_rp <= r_rp;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= vlmr_pkg::t_cmd'(i_command);
            r_msg <= i_message_bytes;
            r_cap <= i_capacity_bytes;
            r_din <= i_data_in;
        end
        if (i_cmd.op == vlmr_pkg::OP_SEND_OPEN) begin
            r_hdr1 <= h_w + PTR_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            case (i_cmd.pad_sel)
                vlmr_pkg::PAD_SEND: r_out_padded <= pad_send;
                vlmr_pkg::PAD_RECV: r_out_padded <= pad_recv;
                default:            r_out_padded <= '0;
            endcase
            r_out_data <= (i_cmd.op == vlmr_pkg::OP_RECV_WORD) ? r_rdata : '0;
            r_out_last <= ((i_cmd.op == vlmr_pkg::OP_SEND_WORD) && (r_sleft == CW'(1)))
                       || ((i_cmd.op == vlmr_pkg::OP_RECV_WORD) && (r_rleft == CW'(1)));
        end
    end

    assign o_status       = r_out_status;
    assign o_padded_bytes = r_out_padded;
    assign o_data_out     = r_out_data;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

/* hw/rtl/variable_length_message_ring.sv */
// A request is latched in IDLE and checked in EVAL; send word, disabled, refused,
// empty and sequence-error requests go on to OUT; send start, receive start and
// receive word pass through HDR1, RDHDR or RDDAT first. One request at a time, held
// in OUT until o_out.ready. The word store is single-write, single-read, registered.
// Reset: synchronous, active low; clears pointers, counters and queue_enable.
// The word store is not cleared and needs no clearing pass.
`default_nettype none

`include "variable_length_message_ring_macros.svh"

module variable_length_message_ring #(
    parameter int QUEUE_BYTES = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vlmr_in_if.sink    i_in,
    vlmr_out_if.source o_out,
    vlmr_cfg_if.sink   i_cfg
);

    vlmr_pkg::t_dp_cmd  dp_cmd;
    vlmr_pkg::t_dp_stat dp_stat;
    logic               in_ready;
    logic               out_valid;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

    vlmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (dp_cmd)
    );

    vlmr_dp #(
        .QUEUE_BYTES (QUEUE_BYTES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .i_command          (i_in.command),
        .i_message_bytes    (i_in.message_bytes),
        .i_capacity_bytes   (i_in.capacity_bytes),
        .i_data_in          (i_in.data_in),
        .i_cfg_valid        (i_cfg.valid),
        .i_cfg_queue_enable (i_cfg.queue_enable),
        .o_status           (o_out.status),
        .o_padded_bytes     (o_out.padded_bytes),
        .o_data_out         (o_out.data_out),
        .o_last             (o_out.last)
    );

    `VLMR_ASSERT_IMP(a_one_side, i_clk, i_rst_n, in_ready, !out_valid, "ready with result")
    `VLMR_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in.valid && in_ready, !in_ready && !out_valid, "no eval after accept")
    `VLMR_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, out_valid && o_out.ready, in_ready, "not idle after result")
    `VLMR_ASSERT_IMP(a_last_ok, i_clk, i_rst_n, out_valid && o_out.last, o_out.status == vlmr_pkg::ST_OK, "last on failed request")

endmodule

`default_nettype wire
